[hw/rtl/wakeup_latency_log2_histogram_defines.svh]
// ----------------------------------------------------------------------------
// Wakeup latency histogram: shared assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAKEUP_LATENCY_LOG2_HISTOGRAM_DEFINES_SVH
`define WAKEUP_LATENCY_LOG2_HISTOGRAM_DEFINES_SVH

// Consequent checked in the same cycle.
`define WLH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WLH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wlh_pkg.sv]
// ----------------------------------------------------------------------------
// Wakeup latency histogram package
// Sizes, event codes and the request types shared by the block.
// ----------------------------------------------------------------------------
package wlh_pkg;

    localparam int TASK_ENTRIES = 16384;
    localparam int HIST_SLOTS   = 32;

    localparam int MODE_W    = 2;
    localparam int TASK_ID_W = 14;
    localparam int TIME_W    = 64;
    localparam int BIN_W     = 5;
    localparam int SLOT_W    = 5;
    localparam int COUNT_W   = 32;

    localparam int TASK_AW   = $clog2(TASK_ENTRIES);
    localparam int SLOT_AW   = $clog2(HIST_SLOTS);
    localparam int NS_PER_US = 1000;
    localparam int LAT_CMP_W = TIME_W + HIST_SLOTS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_WAKE   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_SWITCH = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_READ   = MODE_W'(2);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WAKE,
        OP_SWITCH,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [TASK_AW-1:0]  id;
        logic [TIME_W-1:0]   time_ns;
        logic [BIN_W-1:0]    bin;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } fe_stat_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } be_ctrl_t;

endpackage

[hw/rtl/wlh_event_if.sv]
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one scheduler event request.
// ----------------------------------------------------------------------------
interface wlh_event_if;
    import wlh_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [TASK_ID_W-1:0] task_id;
    logic [TIME_W-1:0]    time_ns;
    logic [BIN_W-1:0]     bin_index;

    modport source (output valid, mode, task_id, time_ns, bin_index, input ready);
    modport sink   (input valid, mode, task_id, time_ns, bin_index, output ready);
endinterface

[hw/rtl/wlh_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result request per event.
// ----------------------------------------------------------------------------
interface wlh_result_if;
    import wlh_pkg::*;

    logic               valid;
    logic               ready;
    logic               counted;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] bin_count;

    modport source (output valid, counted, slot, bin_count, input ready);
    modport sink   (input valid, counted, slot, bin_count, output ready);
endinterface

[hw/rtl/wlh_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

[hw/rtl/wlh_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts events, classifies them and holds them in a short request queue.
// ----------------------------------------------------------------------------
module wlh_front (
    input  logic               clk,
    input  logic               rst_n,
    wlh_event_if.sink          event_ch,
    input  wlh_pkg::be_ctrl_t  be_ctrl,
    output wlh_pkg::fe_stat_t  fe_stat
);
    import wlh_pkg::*;

    req_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    req_t              new_req;
    logic              id_ok;
    logic              push;
    logic              pop;

    always_comb
    begin
        id_ok = (event_ch.task_id != '0) && (32'(event_ch.task_id) < TASK_ENTRIES);
        new_req.id      = TASK_AW'(event_ch.task_id);
        new_req.time_ns = event_ch.time_ns;
        new_req.bin     = event_ch.bin_index;
        new_req.op      = OP_NONE;
        case (event_ch.mode)
            MODE_WAKE:   new_req.op = id_ok ? OP_WAKE : OP_NONE;
            MODE_SWITCH: new_req.op = id_ok ? OP_SWITCH : OP_NONE;
            MODE_READ:   new_req.op = OP_READ;
            default:     new_req.op = OP_NONE;
        endcase
    end

    assign event_ch.ready = !be_ctrl.clearing && (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push           = event_ch.valid && event_ch.ready;
    assign pop            = be_ctrl.pop;
    assign fe_stat.valid  = (cnt_reg != '0);
    assign fe_stat.req    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_req;
        end
    end
endmodule

[hw/rtl/wlh_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Sequencer over the stamp table, log2 of microseconds by threshold compares,
// histogram bins and the result register.
// ----------------------------------------------------------------------------
module wlh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  wlh_pkg::fe_stat_t  fe_stat,
    output wlh_pkg::be_ctrl_t  be_ctrl,
    wlh_result_if.source       result_ch
);
    import wlh_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_LOG   = 6'b001000,
        S_BIN   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [TASK_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [TASK_AW-1:0]  id_reg, id_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [TIME_W-1:0]   diff_reg, diff_next;
    logic [SLOT_AW-1:0]  log_reg, log_next;
    logic                res_counted_reg, res_counted_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [COUNT_W-1:0]  bins_reg [HIST_SLOTS];
    logic                out_valid_reg;
    logic                out_counted_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                stamp_we;
    logic [TASK_AW-1:0]  stamp_waddr;
    logic [TIME_W-1:0]   stamp_wdata;
    logic [TIME_W-1:0]   stamp_rdata;
    logic                valid_we;
    logic [TASK_AW-1:0]  valid_waddr;
    logic                valid_wdata;
    logic                valid_rdata;
    logic                tbl_rd_en;
    logic [TASK_AW-1:0]  tbl_raddr;

    logic [TIME_W:0]     sub;
    logic                later;
    logic [LAT_CMP_W-1:0] diff_wide;
    logic [SLOT_AW-1:0]  log_calc;
    logic [SLOT_AW-1:0]  slot_sel;
    logic [COUNT_W-1:0]  bin_inc;
    logic                bin_we;
    logic                load_out;
    req_t                head;

    wlh_ram #(.WIDTH(TIME_W), .DEPTH(TASK_ENTRIES)) u_stamp_ram (
        .clk     (clk),
        .wr_en   (stamp_we),
        .wr_addr (stamp_waddr),
        .wr_data (stamp_wdata),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_raddr),
        .rd_data (stamp_rdata)
    );

    wlh_ram #(.WIDTH(1), .DEPTH(TASK_ENTRIES)) u_valid_ram (
        .clk     (clk),
        .wr_en   (valid_we),
        .wr_addr (valid_waddr),
        .wr_data (valid_wdata),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_raddr),
        .rd_data (valid_rdata)
    );

    assign head      = fe_stat.req;
    assign sub       = {1'b0, time_reg} - {1'b0, stamp_rdata};
    assign later     = !sub[TIME_W] && (sub[TIME_W-1:0] != '0);
    assign diff_wide = LAT_CMP_W'(diff_reg);

    // floor log2 of diff/1000: highest k with diff >= 1000 << k, last slot caps it
    always_comb
    begin
        log_calc = '0;
        for (int k = 1; k < HIST_SLOTS; k++)
        begin
            if (diff_wide >= (LAT_CMP_W'(NS_PER_US) << k))
            begin
                log_calc = SLOT_AW'(k);
            end
        end
    end

    assign slot_sel = log_reg;
    assign bin_inc  = bins_reg[slot_sel] + COUNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        id_next          = id_reg;
        time_next        = time_reg;
        diff_next        = diff_reg;
        log_next         = log_reg;
        res_counted_next = res_counted_reg;
        res_slot_next    = res_slot_reg;
        res_count_next   = res_count_reg;
        stamp_we         = 1'b0;
        stamp_waddr      = head.id;
        stamp_wdata      = head.time_ns;
        valid_we         = 1'b0;
        valid_waddr      = head.id;
        valid_wdata      = 1'b0;
        tbl_rd_en        = 1'b0;
        tbl_raddr        = head.id;
        bin_we           = 1'b0;
        load_out         = 1'b0;
        be_ctrl.pop      = 1'b0;
        be_ctrl.clearing = (state_reg == S_CLEAR);

        case (state_reg)
            S_CLEAR:
            begin
                valid_we     = 1'b1;
                valid_waddr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == TASK_AW'(TASK_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (fe_stat.valid)
                begin
                    be_ctrl.pop      = 1'b1;
                    id_next          = head.id;
                    time_next        = head.time_ns;
                    res_counted_next = 1'b0;
                    res_slot_next    = '0;
                    res_count_next   = '0;
                    state_next       = S_DONE;
                    case (head.op)
                        OP_WAKE:
                        begin
                            stamp_we    = 1'b1;
                            valid_we    = 1'b1;
                            valid_wdata = 1'b1;
                        end
                        OP_SWITCH:
                        begin
                            tbl_rd_en  = 1'b1;
                            state_next = S_CHECK;
                        end
                        OP_READ:
                        begin
                            res_slot_next = SLOT_W'(head.bin);
                            if (32'(head.bin) < HIST_SLOTS)
                            begin
                                res_count_next = bins_reg[SLOT_AW'(head.bin)];
                            end
                        end
                        default:
                        begin
                            res_slot_next = '0;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (valid_rdata)
                begin
                    valid_we    = 1'b1;
                    valid_waddr = id_reg;
                end
                if (valid_rdata && later)
                begin
                    diff_next  = sub[TIME_W-1:0];
                    state_next = S_LOG;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOG:
            begin
                log_next   = log_calc;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                bin_we           = 1'b1;
                res_counted_next = 1'b1;
                res_slot_next    = SLOT_W'(slot_sel);
                res_count_next   = bin_inc;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_SLOTS; i++)
            begin
                bins_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (bin_we)
            begin
                bins_reg[slot_sel] <= bin_inc;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        time_reg        <= time_next;
        diff_reg        <= diff_next;
        log_reg         <= log_next;
        res_counted_reg <= res_counted_next;
        res_slot_reg    <= res_slot_next;
        res_count_reg   <= res_count_next;
        if (load_out)
        begin
            out_counted_reg <= res_counted_reg;
            out_slot_reg    <= res_slot_reg;
            out_count_reg   <= res_count_reg;
        end
    end

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.counted   = out_counted_reg;
    assign result_ch.slot      = out_slot_reg;
    assign result_ch.bin_count = out_count_reg;
endmodule

[hw/rtl/wakeup_latency_log2_histogram.sv]
// ----------------------------------------------------------------------------
// Wakeup latency log2 histogram
// Records wakeup stamps per task, bins the wait at switch time by floor log2
// of microseconds, and reads bins back.
//
//   channel     dir   handshake      payload
//   event_ch    in    valid/ready    mode, task_id, time_ns, bin_index
//   result_ch   out   valid/ready    counted, slot, bin_count
//
// Wakeup, read and ignored events go from S_IDLE straight to S_DONE.
// A switch reads the table in S_IDLE and compares in S_CHECK; when it adds
// a sample, S_LOG takes log2 from the thresholds 1000 << k and S_BIN
// updates the bin, then S_DONE. After reset the valid table is swept over
// all 16384 entries; event_ch.ready is low. A two-entry request queue
// keeps accepting until full while the back end or result register stalls.
// ----------------------------------------------------------------------------
`include "wakeup_latency_log2_histogram_defines.svh"

module wakeup_latency_log2_histogram (
    input  logic          clk,
    input  logic          rst_n,
    wlh_event_if.sink     event_ch,
    wlh_result_if.source  result_ch
);
    import wlh_pkg::*;

    fe_stat_t fe_stat;
    be_ctrl_t be_ctrl;

    wlh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .event_ch (event_ch),
        .be_ctrl  (be_ctrl),
        .fe_stat  (fe_stat)
    );

    wlh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fe_stat   (fe_stat),
        .be_ctrl   (be_ctrl),
        .result_ch (result_ch)
    );

    `WLH_ASSERT_NOW(a_no_accept_in_clear, be_ctrl.clearing, !event_ch.ready, "ready in clear")
    `WLH_ASSERT_NOW(a_pop_needs_entry, be_ctrl.pop, fe_stat.valid && !be_ctrl.clearing, "bad pop")
    `WLH_ASSERT_NEXT(a_pop_spaced, be_ctrl.pop, !be_ctrl.pop, "pops back to back")
endmodule
